>>> rtl/core/ifre_pkg.sv
// shared types, constants and helpers for the image flip/rotate engine
package ifre_pkg;

  // geometry of the pixel store
  localparam int MAX_DIM    = 256;
  localparam int PIXEL_BITS = 8;
  localparam int DIM_BITS   = $clog2(MAX_DIM);
  localparam int CNT_BITS   = DIM_BITS + 1;
  localparam int ADDR_BITS  = 2 * DIM_BITS;

  typedef logic [DIM_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   dim_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [1:0]            req_t;
  typedef logic [7:0]            op_code_t;
  typedef logic                  cfg_idx_t;

  // request type codes
  localparam req_t REQ_WRITE = 2'd0;
  localparam req_t REQ_OP    = 2'd1;
  localparam req_t REQ_READ  = 2'd2;
  localparam req_t REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CFG_ROW_COUNT = 1'b0;
  localparam cfg_idx_t CFG_COL_COUNT = 1'b1;

  // input item
  typedef struct packed {
    req_t     req_type;
    idx_t     row;
    idx_t     col;
    pixel_t   pixel_in;
    op_code_t op_char;
  } request_t;

  // result item
  typedef struct packed {
    pixel_t pixel_out;
    dim_t   rows_now;
    dim_t   cols_now;
    logic   read_ok;
  } result_t;

  // store access and dimensions from the transform stage
  typedef struct packed {
    logic  wr_en;
    logic  rd_ok;
    addr_t addr;
    dim_t  rows_now;
    dim_t  cols_now;
  } xf_t;

  // saturate a dimension register value to 1..MAX_DIM
  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > dim_t'(MAX_DIM)) begin
      r = dim_t'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/image_flip_rotate_engine.sv
// top level of the image flip/rotate engine: config, item register, pixel store, result stage
// a result strobes on done once its item has passed the item register and the result stage
// throughput: one item per cycle, busy stays low; the single store port serves one item a cycle
// results cannot be held off: done lasts one cycle and the receiver takes it
// reset clears the orientation and sets both dimension registers to 1
// the pixel store is not cleared by reset; cells hold garbage until written
module image_flip_rotate_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ifre_pkg::request_t request,
  output logic               done,
  output ifre_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  ifre_pkg::cfg_idx_t cfg_index,
  input  ifre_pkg::dim_t     cfg_data
);
  import ifre_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

  dim_t     row_count, col_count;
  logic     item_vld;
  request_t item;
  xf_t      xf;
  logic     read_ok;
  dim_t     rows_now, cols_now;
  pixel_t   rd_data;
  pixel_t   store [STORE_DEPTH];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= dim_t'(1);
      col_count <= dim_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count <= clamp_dim(cfg_data);
        CFG_COL_COUNT: col_count <= clamp_dim(cfg_data);
        default:       row_count <= row_count;
      endcase
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= request;
    end
  end

  // orientation and address mapping
  ifre_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .vld       (item_vld),
    .item      (item),
    .row_count (row_count),
    .col_count (col_count),
    .xf        (xf)
  );

  // pixel store, one access per item
  always_ff @(posedge clk) begin
    if (xf.wr_en) begin
      store[xf.addr] <= item.pixel_in;
    end
    rd_data <= store[xf.addr];
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    read_ok  <= xf.rd_ok;
    rows_now <= xf.rows_now;
    cols_now <= xf.cols_now;
  end

  assign result.pixel_out = read_ok ? rd_data : '0;
  assign result.rows_now  = rows_now;
  assign result.cols_now  = cols_now;
  assign result.read_ok   = read_ok;

endmodule

>>> rtl/core/ifre_xform.sv
// orientation state, operation decode and position mapping into the pixel store
module ifre_xform (
  input  logic              clk,
  input  logic              rst,
  input  logic              vld,
  input  ifre_pkg::request_t item,
  input  ifre_pkg::dim_t    row_count,
  input  ifre_pkg::dim_t    col_count,
  output ifre_pkg::xf_t     xf
);
  import ifre_pkg::*;

  // ascii operation codes
  localparam op_code_t OP_H   = 8'h48;
  localparam op_code_t OP_V   = 8'h56;
  localparam op_code_t OP_B   = 8'h42;
  localparam op_code_t OP_Y   = 8'h59;
  localparam op_code_t OP_ONE = 8'h31;
  localparam op_code_t OP_TWO = 8'h32;
  localparam op_code_t OP_A   = 8'h41;
  localparam op_code_t OP_Z   = 8'h5A;
  localparam op_code_t OP_C   = 8'h43;
  localparam op_code_t OP_X   = 8'h58;

  logic swapped, flip_r, flip_c;
  logic swapped_next, flip_r_next, flip_c_next;
  dim_t row_ext, col_ext;
  dim_t rows_now, cols_now;
  dim_t oi, oj;
  logic in_range;

  // next orientation, every bit from the old values
  always_comb begin
    swapped_next = swapped;
    flip_r_next  = flip_r;
    flip_c_next  = flip_c;
    if (vld && item.req_type == REQ_OP) begin
      unique case (item.op_char)
        OP_H: begin
          flip_r_next = !flip_r;
        end
        OP_V: begin
          flip_c_next = !flip_c;
        end
        OP_B, OP_Y: begin
          flip_r_next = !flip_r;
          flip_c_next = !flip_c;
        end
        OP_ONE: begin
          swapped_next = !swapped;
          flip_r_next  = flip_c;
          flip_c_next  = flip_r;
        end
        OP_TWO: begin
          swapped_next = !swapped;
          flip_r_next  = !flip_c;
          flip_c_next  = !flip_r;
        end
        OP_A, OP_Z: begin
          swapped_next = !swapped;
          flip_r_next  = flip_c;
          flip_c_next  = !flip_r;
        end
        OP_C, OP_X: begin
          swapped_next = !swapped;
          flip_r_next  = !flip_c;
          flip_c_next  = flip_r;
        end
        default: begin
          swapped_next = swapped;
        end
      endcase
    end
  end

  // orientation registers
  always_ff @(posedge clk) begin
    if (rst) begin
      swapped <= 1'b0;
      flip_r  <= 1'b0;
      flip_c  <= 1'b0;
    end else begin
      swapped <= swapped_next;
      flip_r  <= flip_r_next;
      flip_c  <= flip_c_next;
    end
  end

  // dimensions in the current orientation
  assign rows_now = swapped_next ? col_count : row_count;
  assign cols_now = swapped_next ? row_count : col_count;
  assign row_ext  = {1'b0, item.row};
  assign col_ext  = {1'b0, item.col};

  // map position to original cell: writes use it as is, reads go through the orientation
  always_comb begin
    oi       = row_ext;
    oj       = col_ext;
    in_range = 1'b0;
    priority if (item.req_type == REQ_WRITE) begin
      in_range = (row_ext < row_count) && (col_ext < col_count);
    end else if (item.req_type == REQ_READ) begin
      in_range = (row_ext < rows_now) && (col_ext < cols_now);
      if (!swapped_next) begin
        oi = flip_r_next ? row_count - dim_t'(1) - row_ext : row_ext;
        oj = flip_c_next ? col_count - dim_t'(1) - col_ext : col_ext;
      end else begin
        oi = flip_c_next ? row_count - dim_t'(1) - col_ext : col_ext;
        oj = flip_r_next ? col_count - dim_t'(1) - row_ext : row_ext;
      end
    end else begin
      in_range = 1'b0;
    end
  end

  assign xf.wr_en    = vld && item.req_type == REQ_WRITE && in_range;
  assign xf.rd_ok    = vld && item.req_type == REQ_READ && in_range;
  assign xf.addr     = {oi[DIM_BITS-1:0], oj[DIM_BITS-1:0]};
  assign xf.rows_now = rows_now;
  assign xf.cols_now = cols_now;

endmodule

>>> rtl/core/ifre_checker.sv
// port-level checks for the image flip/rotate engine, bound to the top level
module ifre_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input ifre_pkg::request_t request,
  input logic               done,
  input ifre_pkg::result_t  result
);
  import ifre_pkg::*;

  // every accepted item later gives a result on done
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  // no result without an earlier accepted item
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 2))
    else $error("result without accepted item");

  // read_ok only comes back for a read item
  a_ok_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_ok) |-> $past(request.req_type == REQ_READ, 2))
    else $error("read_ok on a non-read item");

  // anything but a good read shows a zero pixel
  a_zero_pixel: assert property (@(posedge clk) disable iff (rst)
    (done && !result.read_ok) |-> (result.pixel_out == '0))
    else $error("nonzero pixel without read_ok");

endmodule

bind image_flip_rotate_engine ifre_checker u_ifre_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// testbench for the image flip/rotate engine: directed and random items against an orientation model
module tb;
  import ifre_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 100;

  // operation codes
  localparam op_code_t OP_FLIP_H      = "H";
  localparam op_code_t OP_FLIP_V      = "V";
  localparam op_code_t OP_FLIP_BOTH_B = "B";
  localparam op_code_t OP_FLIP_BOTH_Y = "Y";
  localparam op_code_t OP_TRANSPOSE   = "1";
  localparam op_code_t OP_ANTI_TRANS  = "2";
  localparam op_code_t OP_ROT_A       = "A";
  localparam op_code_t OP_ROT_Z       = "Z";
  localparam op_code_t OP_ROT_C       = "C";
  localparam op_code_t OP_ROT_X       = "X";
  localparam op_code_t OP_UNKNOWN     = "Q";

  // orientation, dimensions and pixel store as the block should hold them
  class orientation_tracker;
    int unsigned n_rows;
    int unsigned n_cols;
    bit          swapped;
    bit          flip_r;
    bit          flip_c;
    pixel_t      image [MAX_DIM*MAX_DIM];
    bit          written [MAX_DIM*MAX_DIM];
    int unsigned written_cells [$];
    result_t     pending_results [$];
    int          errors;

    function new();
      n_rows  = 1;
      n_cols  = 1;
      swapped = 0;
      flip_r  = 0;
      flip_c  = 0;
      errors  = 0;
    endfunction

    function void set_dim(cfg_idx_t idx, dim_t value);
      int unsigned v;
      v = (value == 0) ? 1 : (value > MAX_DIM) ? MAX_DIM : value;
      if (idx == CFG_ROW_COUNT) begin
        n_rows = v;
      end else begin
        n_cols = v;
      end
    endfunction

    function int unsigned rows_now();
      return swapped ? n_cols : n_rows;
    endfunction

    function int unsigned cols_now();
      return swapped ? n_rows : n_cols;
    endfunction

    // new flip bits come from the old ones
    function void rotate(op_code_t code);
      bit fr;
      bit fc;
      fr = flip_r;
      fc = flip_c;
      case (code)
        OP_FLIP_H: flip_r = !fr;
        OP_FLIP_V: flip_c = !fc;
        OP_FLIP_BOTH_B, OP_FLIP_BOTH_Y: begin
          flip_r = !fr;
          flip_c = !fc;
        end
        OP_TRANSPOSE: begin
          flip_r  = fc;
          flip_c  = fr;
          swapped = !swapped;
        end
        OP_ANTI_TRANS: begin
          flip_r  = !fc;
          flip_c  = !fr;
          swapped = !swapped;
        end
        OP_ROT_A, OP_ROT_Z: begin
          flip_r  = fc;
          flip_c  = !fr;
          swapped = !swapped;
        end
        OP_ROT_C, OP_ROT_X: begin
          flip_r  = !fc;
          flip_c  = fr;
          swapped = !swapped;
        end
        default: ;
      endcase
    endfunction

    // apply one accepted item and queue the result it must give
    function void note_item(request_t item);
      result_t exp;
      int unsigned oi;
      int unsigned oj;
      int unsigned slot;
      if (item.req_type == REQ_WRITE && item.row < n_rows && item.col < n_cols) begin
        slot = item.row * MAX_DIM + item.col;
        image[slot] = item.pixel_in;
        if (!written[slot]) begin
          written[slot] = 1;
          written_cells.push_back(slot);
        end
      end else if (item.req_type == REQ_OP) begin
        rotate(item.op_char);
      end
      exp = '0;
      exp.rows_now = dim_t'(rows_now());
      exp.cols_now = dim_t'(cols_now());
      if (item.req_type == REQ_READ && item.row < rows_now() && item.col < cols_now()) begin
        if (!swapped) begin
          oi = flip_r ? n_rows - 1 - item.row : item.row;
          oj = flip_c ? n_cols - 1 - item.col : item.col;
        end else begin
          oi = flip_c ? n_rows - 1 - item.col : item.col;
          oj = flip_r ? n_cols - 1 - item.row : item.row;
        end
        exp.pixel_out = image[oi * MAX_DIM + oj];
        exp.read_ok   = 1'b1;
      end
      pending_results.push_back(exp);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: %h", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.pixel_out !== exp.pixel_out) begin
        $error("pixel_out: expected %0d, got %0d", exp.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.rows_now !== exp.rows_now) begin
        $error("rows_now: expected %0d, got %0d", exp.rows_now, got.rows_now);
        errors++;
      end
      if (got.cols_now !== exp.cols_now) begin
        $error("cols_now: expected %0d, got %0d", exp.cols_now, got.cols_now);
        errors++;
      end
      if (got.read_ok !== exp.read_ok) begin
        $error("read_ok: expected %0d, got %0d", exp.read_ok, got.read_ok);
        errors++;
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     start     = 1'b0;
  logic     busy;
  request_t request   = '0;
  logic     done;
  result_t  result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_ROW_COUNT;
  dim_t     cfg_data  = '0;

  orientation_tracker tracker;
  int unsigned        cycles = 0;

  image_flip_rotate_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // results are taken in the cycle they strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result(result);
    end
  end

  function automatic request_t mk(req_t rq, idx_t r, idx_t c, pixel_t p, op_code_t op);
    request_t item;
    item.req_type = rq;
    item.row      = r;
    item.col      = c;
    item.pixel_in = p;
    item.op_char  = op;
    return item;
  endfunction

  function automatic op_code_t pick_op(int k);
    case (k)
      0: return OP_FLIP_H;
      1: return OP_FLIP_V;
      2: return OP_FLIP_BOTH_B;
      3: return OP_FLIP_BOTH_Y;
      4: return OP_TRANSPOSE;
      5: return OP_ANTI_TRANS;
      6: return OP_ROT_A;
      7: return OP_ROT_Z;
      8: return OP_ROT_C;
      default: return OP_ROT_X;
    endcase
  endfunction

  function automatic request_t rand_fields();
    return mk(req_t'($urandom_range(0, 3)), idx_t'($urandom), idx_t'($urandom),
              pixel_t'($urandom), op_code_t'($urandom));
  endfunction

  // a read on a written pixel or outside the frame, else an unused request type
  function automatic request_t make_read(bit want_hit);
    request_t    item;
    int unsigned slot;
    int unsigned i;
    int unsigned j;
    int unsigned lo;
    int unsigned rn;
    int unsigned cn;
    bit          found;
    item          = rand_fields();
    item.req_type = REQ_READ;
    rn            = tracker.rows_now();
    cn            = tracker.cols_now();
    found         = 0;
    if (want_hit || (rn == MAX_DIM && cn == MAX_DIM)) begin
      for (int t = 0; t < 16 && !found && tracker.written_cells.size() > 0; t++) begin
        lo = (tracker.written_cells.size() > 64 && $urandom_range(0, 1)) ?
             tracker.written_cells.size() - 64 : 0;
        slot  = tracker.written_cells[$urandom_range(lo, tracker.written_cells.size() - 1)];
        i     = slot / MAX_DIM;
        j     = slot % MAX_DIM;
        found = (i < tracker.n_rows && j < tracker.n_cols);
      end
    end
    if (found) begin
      // invert the current mapping
      if (!tracker.swapped) begin
        item.row = idx_t'(tracker.flip_r ? tracker.n_rows - 1 - i : i);
        item.col = idx_t'(tracker.flip_c ? tracker.n_cols - 1 - j : j);
      end else begin
        item.row = idx_t'(tracker.flip_r ? tracker.n_cols - 1 - j : j);
        item.col = idx_t'(tracker.flip_c ? tracker.n_rows - 1 - i : i);
      end
    end else if (rn < MAX_DIM && ($urandom_range(0, 1) || cn == MAX_DIM)) begin
      item.row = idx_t'($urandom_range(rn, MAX_DIM - 1));
    end else if (cn < MAX_DIM) begin
      item.col = idx_t'($urandom_range(cn, MAX_DIM - 1));
    end else begin
      item.req_type = REQ_NONE;
    end
    return item;
  endfunction

  // random mix: writes, operations, reads and unused request types
  function automatic request_t make_item();
    request_t item;
    int       roll;
    roll = $urandom_range(0, 99);
    item = rand_fields();
    if (roll < 35) begin
      item.req_type = REQ_WRITE;
      if ($urandom_range(0, 6) != 0) begin
        item.row = idx_t'($urandom_range(0, tracker.n_rows - 1));
        item.col = idx_t'($urandom_range(0, tracker.n_cols - 1));
      end
    end else if (roll < 55) begin
      item.req_type = REQ_OP;
      if ($urandom_range(0, 6) != 0) begin
        item.op_char = pick_op($urandom_range(0, 9));
      end
    end else if (roll < 95) begin
      item = make_read($urandom_range(0, 4) != 0);
    end else begin
      item.req_type = REQ_NONE;
    end
    return item;
  endfunction

  task automatic send_item(request_t item);
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy);
    tracker.note_item(item);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every queued result, then idle with start low
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both dimension registers, valid held across the pair
  task automatic set_dims(dim_t rows, dim_t cols);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_dim(CFG_ROW_COUNT, rows);
    cfg_index <= CFG_COL_COUNT;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_dim(CFG_COL_COUNT, cols);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    dim_t rows_cfg;
    dim_t cols_cfg;
    bit   quiet;
    tracker = new();
    quiet   = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset dimensions
    send_item(mk(REQ_NONE, 8'd0, 8'd0, 8'h00, 8'h00));
    drain();
    set_dims(9'd2, 9'd3);

    // fill a 2x3 frame, then writes outside it and two reads
    send_item(mk(REQ_WRITE, 8'd0, 8'd0, 8'h00, 8'h00));
    send_item(mk(REQ_WRITE, 8'd0, 8'd1, 8'hff, 8'h00));
    send_item(mk(REQ_WRITE, 8'd0, 8'd2, 8'h5a, 8'h00));
    send_item(mk(REQ_WRITE, 8'd1, 8'd0, 8'ha5, 8'h00));
    send_item(mk(REQ_WRITE, 8'd1, 8'd1, 8'h01, 8'h00));
    send_item(mk(REQ_WRITE, 8'd1, 8'd2, 8'h80, 8'h00));
    send_item(mk(REQ_WRITE, 8'd2, 8'd0, 8'h77, 8'h00));
    send_item(mk(REQ_WRITE, 8'd255, 8'd255, 8'hee, 8'h00));
    send_item(mk(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00));
    send_item(mk(REQ_READ, 8'd1, 8'd2, 8'h00, 8'h00));

    // every operation, with reads between
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_FLIP_H));
    send_item(mk(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_FLIP_V));
    send_item(mk(REQ_READ, 8'd0, 8'd1, 8'h00, 8'h00));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_FLIP_BOTH_B));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_FLIP_BOTH_Y));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_TRANSPOSE));
    send_item(mk(REQ_READ, 8'd2, 8'd1, 8'h00, 8'h00));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_ANTI_TRANS));
    send_item(mk(REQ_READ, 8'd0, 8'd1, 8'h00, 8'h00));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_ROT_A));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_ROT_Z));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_ROT_C));
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_ROT_X));
    send_item(mk(REQ_READ, 8'd1, 8'd0, 8'h00, 8'h00));

    // unknown code, read out of range, unused request type
    send_item(mk(REQ_OP, 8'd0, 8'd0, 8'h00, OP_UNKNOWN));
    send_item(mk(REQ_READ, 8'd255, 8'd255, 8'h00, 8'h00));
    send_item(mk(REQ_NONE, 8'd255, 8'd255, 8'hff, 8'hff));

    // random phases, each with its own frame size
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin rows_cfg = 9'd0;   cols_cfg = 9'd511; end
        1: begin rows_cfg = 9'd256; cols_cfg = 9'd256; end
        2: begin rows_cfg = 9'd257; cols_cfg = 9'd1;   end
        3: begin
          rows_cfg = dim_t'($urandom_range(1, 8));
          cols_cfg = dim_t'($urandom_range(1, 8));
        end
        4: begin
          rows_cfg = dim_t'($urandom_range(1, 16));
          cols_cfg = dim_t'($urandom_range(1, 16));
        end
        default: begin
          rows_cfg = dim_t'($urandom_range(0, 511));
          cols_cfg = dim_t'($urandom_range(0, 511));
        end
      endcase
      set_dims(rows_cfg, cols_cfg);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretches with and without gaps; none in the last phase
        if (n % 20 == 0) begin
          quiet = (p == PHASES - 1) || ($urandom_range(0, 2) == 0);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
          idle($urandom_range(1, 14));
        end
        send_item(make_item());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (tracker.pending_results.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_results.size());
    end
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
